// ----- hw/rtl/dfb_pkg.sv -----
// Shared types, constants and helpers for the depth fog blend block.
// Used by dfb_density, dfb_blend and depth_fog_blend_top; depends on nothing.
package dfb_pkg;

  localparam int unsigned ColorW  = 27;
  localparam int unsigned DepthW  = 24;
  localparam int unsigned DensW   = 7;
  localparam int unsigned NumDens = 32;
  localparam int unsigned BankW   = 56;
  localparam int unsigned OffW    = 15;
  localparam int unsigned ShiftW  = 4;
  localparam int unsigned FogColW = 21;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW = 56;
  localparam int unsigned OutDataW = 32;

  // Largest step is 1024 depth units of 512; shifts above MaxShift give step zero.
  localparam logic [ShiftW-1:0] MaxShift = 4'd10;
  localparam logic [10:0]       MaxStep  = 11'd1024;
  localparam logic [4:0]        LastIdx  = 5'd31;

  typedef enum logic [1:0] {
    FOG_OFF   = 2'd0,
    FOG_FULL  = 2'd1,
    FOG_ALPHA = 2'd2
  } fog_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE       = 3'd0,
    REG_SHIFT      = 3'd1,
    REG_COLOR      = 3'd2,
    REG_OFFSET     = 3'd3,
    REG_DENS_LO    = 3'd4,
    REG_DENS_MID   = 3'd5,
    REG_DENS_UPPER = 3'd6,
    REG_DENS_TOP   = 3'd7
  } cfg_reg_e;

  typedef logic [NumDens-1:0][DensW-1:0] dens_tbl_t;

  // Hand-off from the density pipeline to the blend pipeline.
  typedef struct packed {
    logic              valid;
    logic              fog_en;
    logic [ColorW-1:0] pix;
    logic [DensW-1:0]  dens;
  } dens_out_t;

  // Expand a 5-bit color channel to 6 bits: v*2 plus one when v is nonzero.
  function automatic logic [5:0] expand5(input logic [4:0] v);
    expand5 = {v, |v};
  endfunction

endpackage

// ----- hw/rtl/dfb_density.sv -----
// Density pipeline: depth offset, table lookup, interpolation products and final density.
// Four register stages; depends on dfb_pkg.
module dfb_density
  import dfb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic                 fog_en_i,
  input  logic [ColorW-1:0]    pix_i,
  input  logic [DepthW-1:0]    depth_i,
  input  logic [ShiftW-1:0]    fog_shift_i,
  input  logic [OffW-1:0]      fog_offset_i,
  input  dens_tbl_t            dens_tbl_i,
  output dens_out_t            out_o
);

  // Stage 1: signed offset from the table start.
  logic              v1_q, en1_q;
  logic [ColorW-1:0] pix1_q;
  logic [OffW:0]     off1_d, off1_q;

  assign off1_d = {1'b0, depth_i[DepthW-1 -: OffW]} - {1'b0, fog_offset_i};

  // Stage 2: pick the two entries and their weights.
  logic              v2_q, en2_q;
  logic [ColorW-1:0] pix2_q;
  logic [DensW-1:0]  elo2_d, elo2_q, ehi2_d, ehi2_q;
  logic [10:0]       wlo2_d, wlo2_q;
  logic [9:0]        whi2_d, whi2_q;
  logic [3:0]        k2_d, k2_q;

  logic [10:0]     step;
  logic [9:0]      mask;
  logic [9:0]      m;
  logic [3:0]      k;
  logic [OffW-1:0] n;
  logic            neg;
  logic            step_zero;

  always_comb begin
    step      = MaxStep >> fog_shift_i;
    mask      = 10'(step - 11'd1);
    step_zero = (fog_shift_i > MaxShift);
    k         = step_zero ? 4'd0 : 4'(MaxShift - fog_shift_i);
    neg       = off1_q[OffW];
    n         = off1_q[OffW-1:0] >> k;
    m         = off1_q[9:0] & mask;

    elo2_d = dens_tbl_i[0];
    ehi2_d = '0;
    wlo2_d = 11'd1;
    whi2_d = '0;
    k2_d   = 4'd0;
    priority if (step_zero) begin
      if (!neg && (off1_q != '0)) begin
        elo2_d = dens_tbl_i[LastIdx];
      end
    end else if (neg) begin
      elo2_d = dens_tbl_i[0];
    end else if (n >= OffW'(LastIdx)) begin
      elo2_d = dens_tbl_i[LastIdx];
    end else begin
      elo2_d = dens_tbl_i[n[4:0]];
      ehi2_d = dens_tbl_i[5'(n[4:0] + 5'd1)];
      wlo2_d = step - {1'b0, m};
      whi2_d = m;
      k2_d   = k;
    end
  end

  // Stage 3: weighted products.
  logic              v3_q, en3_q;
  logic [ColorW-1:0] pix3_q;
  logic [17:0]       plo3_d, plo3_q;
  logic [16:0]       phi3_d, phi3_q;
  logic [3:0]        k3_q;

  assign plo3_d = 18'(elo2_q) * 18'(wlo2_q);
  assign phi3_d = 17'(ehi2_q) * 17'(whi2_q);

  // Stage 4: sum and scale by the step.
  logic              v4_q, en4_q;
  logic [ColorW-1:0] pix4_q;
  logic [DensW-1:0]  d4_d, d4_q;
  logic [18:0]       wsum;

  assign wsum = {1'b0, plo3_q} + {2'b0, phi3_q};
  assign d4_d = DensW'(wsum >> k3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      en1_q  <= fog_en_i;
      pix1_q <= pix_i;
      off1_q <= off1_d;
      en2_q  <= en1_q;
      pix2_q <= pix1_q;
      elo2_q <= elo2_d;
      ehi2_q <= ehi2_d;
      wlo2_q <= wlo2_d;
      whi2_q <= whi2_d;
      k2_q   <= k2_d;
      en3_q  <= en2_q;
      pix3_q <= pix2_q;
      plo3_q <= plo3_d;
      phi3_q <= phi3_d;
      k3_q   <= k2_q;
      en4_q  <= en3_q;
      pix4_q <= pix3_q;
      d4_q   <= d4_d;
    end
  end

  assign out_o = '{valid: v4_q, fog_en: en4_q, pix: pix4_q, dens: d4_q};

endmodule

// ----- hw/rtl/dfb_blend.sv -----
// Blend pipeline: per-channel fog and pixel products, then sums and result assembly.
// Two register stages, the second being the output register; depends on dfb_pkg.
module dfb_blend
  import dfb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  dens_out_t            in_i,
  input  fog_mode_e            fog_mode_i,
  input  logic [FogColW-1:0]   fog_color_i,
  output logic                 valid_o,
  output logic [ColorW-1:0]    color_o,
  output logic                 applied_o
);

  // Channel order: r, g, b, a.
  logic [3:0][5:0]  fog_ch;
  logic [3:0][5:0]  pix_ch;
  logic [7:0]       inv_d;
  logic [3:0][12:0] pf5_d, pf5_q, pp5_d, pp5_q;

  assign fog_ch[0] = expand5(fog_color_i[4:0]);
  assign fog_ch[1] = expand5(fog_color_i[9:5]);
  assign fog_ch[2] = expand5(fog_color_i[14:10]);
  assign fog_ch[3] = expand5(fog_color_i[20:16]);
  assign pix_ch[0] = in_i.pix[5:0];
  assign pix_ch[1] = in_i.pix[11:6];
  assign pix_ch[2] = in_i.pix[17:12];
  assign pix_ch[3] = in_i.pix[23:18];
  assign inv_d     = 8'd128 - {1'b0, in_i.dens};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pf5_d[i] = 13'(fog_ch[i]) * 13'(in_i.dens);
      pp5_d[i] = 13'(pix_ch[i]) * 13'(inv_d);
    end
  end

  logic              v5_q, en5_q;
  logic [ColorW-1:0] pix5_q;

  // Output stage.
  logic [3:0][12:0]  csum;
  logic [3:0][5:0]   mixed;
  logic [ColorW-1:0] color_d, color_q;
  logic              v6_q, applied_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      csum[i]  = pf5_q[i] + pp5_q[i];
      mixed[i] = csum[i][12:7];
    end
    if (!en5_q) begin
      color_d = pix5_q;
    end else if (fog_mode_i == FOG_FULL) begin
      color_d = {1'b1, 2'b00, mixed[3], mixed[2], mixed[1], mixed[0]};
    end else begin
      color_d = {pix5_q[26:24], mixed[3], pix5_q[17:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv_i) begin
      v5_q <= in_i.valid;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      en5_q     <= in_i.fog_en;
      pix5_q    <= in_i.pix;
      pf5_q     <= pf5_d;
      pp5_q     <= pp5_d;
      color_q   <= color_d;
      applied_q <= en5_q;
    end
  end

  assign valid_o   = v6_q;
  assign color_o   = color_q;
  assign applied_o = applied_q;

endmodule

// ----- hw/rtl/depth_fog_blend_top.sv -----
// Top level of the depth fog blend block: configuration registers, stream handshake,
// and the density and blend pipelines. Depends on dfb_pkg, dfb_density and dfb_blend.
//
// Per-pixel table fog on a stream of RGBA6 pixels. Each input item carries a pixel,
// its 24-bit depth and a fog flag; each item produces exactly one result item, in
// order. The depth selects a density from a 32-entry, 7-bit table, interpolated
// linearly between entries, and the expanded fog color is blended into the pixel by
// that density. The datapath is a six-stage pipeline: four stages build the density
// (offset subtract, table lookup, weight products, sum and scale) and two blend the
// channels (products, then sums into the output register). One item is accepted per
// clock; the whole pipeline advances together and holds while a finished result
// waits on a stalled output, so s_axis_tready falls only when the output register
// is full and not being taken. Configuration must be written only while no item is
// in flight; the pipeline reads the registers directly in each stage.
module depth_fog_blend_top
  import dfb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [BankW-1:0]    cfg_data_i,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // pixel_color [26:0], pixel_depth [50:27]
  input  logic                s_axis_tuser,  // fog_flag
  // Output stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // result_color [26:0]
  output logic                m_axis_tuser   // fog_applied
);

  // Configuration registers.
  fog_mode_e          fog_mode_q;
  logic [ShiftW-1:0]  fog_shift_q;
  logic [FogColW-1:0] fog_color_q;
  logic [OffW-1:0]    fog_offset_q;
  logic [BankW-1:0]   dens_lo_q, dens_mid_q, dens_upper_q, dens_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fog_mode_q   <= FOG_OFF;
      fog_shift_q  <= '0;
      fog_color_q  <= '0;
      fog_offset_q <= '0;
      dens_lo_q    <= '0;
      dens_mid_q   <= '0;
      dens_upper_q <= '0;
      dens_top_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:       fog_mode_q   <= fog_mode_e'(cfg_data_i[1:0]);
        REG_SHIFT:      fog_shift_q  <= cfg_data_i[ShiftW-1:0];
        REG_COLOR:      fog_color_q  <= cfg_data_i[FogColW-1:0];
        REG_OFFSET:     fog_offset_q <= cfg_data_i[OffW-1:0];
        REG_DENS_LO:    dens_lo_q    <= cfg_data_i;
        REG_DENS_MID:   dens_mid_q   <= cfg_data_i;
        REG_DENS_UPPER: dens_upper_q <= cfg_data_i;
        REG_DENS_TOP:   dens_top_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The table packs entry 0 into the lowest bits of the low bank.
  dens_tbl_t dens_tbl;
  assign dens_tbl = {dens_top_q, dens_upper_q, dens_mid_q, dens_lo_q};

  // The pipeline moves whenever the output register is empty or being taken.
  logic out_valid;
  logic adv;
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;

  // Fog applies only when a mode is selected and the pixel's flag is set.
  logic fog_en;
  assign fog_en = (fog_mode_q != FOG_OFF) && s_axis_tuser;

  dens_out_t dens_out;

  dfb_density u_density (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (s_axis_tvalid),
    .fog_en_i     (fog_en),
    .pix_i        (s_axis_tdata[ColorW-1:0]),
    .depth_i      (s_axis_tdata[ColorW +: DepthW]),
    .fog_shift_i  (fog_shift_q),
    .fog_offset_i (fog_offset_q),
    .dens_tbl_i   (dens_tbl),
    .out_o        (dens_out)
  );

  logic [ColorW-1:0] result_color;
  logic              fog_applied;

  dfb_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_i        (dens_out),
    .fog_mode_i  (fog_mode_q),
    .fog_color_i (fog_color_q),
    .valid_o     (out_valid),
    .color_o     (result_color),
    .applied_o   (fog_applied)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OutDataW - ColorW){1'b0}}, result_color};
  assign m_axis_tuser  = fog_applied;

endmodule

// ----- sim/depth_fog_blend_top_tb.sv -----
// Self-checking testbench for depth_fog_blend_top: drives pixel items with random idling
// on both stream sides and checks every result against a behavioral fog predictor.
// Depends on dfb_pkg and the depth_fog_blend_top RTL.
module depth_fog_blend_top_tb
  import dfb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The mode field has one code without a name in the package; the block treats it
  // exactly like alpha-only mode.
  localparam logic [1:0] ModeReserved = 2'd3;
  localparam int         LastEntry    = 31;
  localparam int         DensScale    = 128;
  localparam int         MaxPrinted   = 40;

  // One pixel item as the sender sees it.
  typedef struct {
    logic [ColorW-1:0] color;
    logic [DepthW-1:0] depth;
    logic              flag;
  } pixel_in_t;

  // One result item as predicted.
  typedef struct {
    logic [ColorW-1:0] color;
    logic              applied;
  } pixel_out_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = REG_MODE;
  logic [BankW-1:0]    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  // Shadow copy of the configuration registers, updated as each write is issued.
  logic [1:0]          fog_mode_r;
  logic [ShiftW-1:0]   fog_shift_r;
  logic [FogColW-1:0]  fog_color_r;
  logic [OffW-1:0]     fog_offset_r;
  logic [BankW-1:0]    dens_bank_r [4];

  pixel_in_t  pixels_to_send [$];
  pixel_out_t expected_pixels [$];
  pixel_in_t  next_px;

  // Idling knobs, set per phase by the stimulus and read by the stream processes.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int sink_hold_req = 0;
  int send_gap      = 0;
  int sink_gap      = 0;
  int hold_left     = 0;
  int mismatches    = 0;

  depth_fog_blend_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fog predictor
  // ---------------------------------------------------------------------------

  // Seven-bit density entry from the shadow table.
  function automatic int dens_entry(int idx);
    return int'(dens_bank_r[idx / 8][(idx % 8) * DensW +: DensW]);
  endfunction

  // Widen a five-bit fog channel to six bits; zero stays zero, anything else gains a one.
  function automatic int widen_channel(logic [4:0] v);
    int val;
    val = int'(v);
    return val * 2 + (val + 31) / 32;
  endfunction

  // Weighted average of fog and pixel channel by density out of 128, truncated.
  function automatic logic [5:0] mix_channel(int fog, logic [5:0] pix, int dens);
    return 6'((fog * dens + int'(pix) * (DensScale - dens)) / DensScale);
  endfunction

  function automatic pixel_out_t fogged_pixel(pixel_in_t px);
    pixel_out_t res;
    int         offset;
    int         step;
    int         n;
    int         m;
    int         dens;
    logic [5:0] a;
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
    res.color   = px.color;
    res.applied = 1'b0;
    if (fog_mode_r == FOG_OFF || !px.flag) return res;

    // Depth in units of 512, measured from the start of the table.
    offset = int'(px.depth[DepthW-1:9]) - int'(fog_offset_r);
    step   = 1024 >> fog_shift_r;
    if (step == 0) begin
      dens = dens_entry(offset > 0 ? LastEntry : 0);
    end else begin
      // Division and remainder truncate toward zero, so a small negative offset
      // lands on entry zero through its negative remainder.
      n = offset / step;
      m = offset % step;
      if (n >= LastEntry) begin
        dens = dens_entry(LastEntry);
      end else if (n < 0 || m < 0) begin
        dens = dens_entry(0);
      end else begin
        dens = (dens_entry(n + 1) * m + dens_entry(n) * (step - m)) / step;
      end
    end

    a = mix_channel(widen_channel(fog_color_r[20:16]), px.color[23:18], dens);
    if (fog_mode_r == FOG_FULL) begin
      r = mix_channel(widen_channel(fog_color_r[4:0]), px.color[5:0], dens);
      g = mix_channel(widen_channel(fog_color_r[9:5]), px.color[11:6], dens);
      b = mix_channel(widen_channel(fog_color_r[14:10]), px.color[17:12], dens);
      res.color = {1'b1, 2'b00, a, b, g, r};
    end else begin
      // Alpha-only, and the reserved mode code: every bit but alpha passes through.
      res.color[23:18] = a;
    end
    res.applied = 1'b1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  // A gap at the given percentage, mostly short and a few long; otherwise no gap.
  function automatic int pick_gap(int pct);
    if (int'($urandom_range(99)) >= pct) return 0;
    if ($urandom_range(9) == 0) return int'($urandom_range(8, 40));
    return int'($urandom_range(1, 3));
  endfunction

  // Random bits above a register's width now and then; the block must drop them.
  function automatic logic [BankW-1:0] junk_above(int w);
    logic [BankW-1:0] v;
    v = BankW'({$urandom, $urandom});
    if ($urandom_range(3) != 0) return '0;
    return v & ~((56'd1 << w) - 56'd1);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // One register write; the shadow copy follows at once since the block is idle.
  task automatic write_reg(cfg_reg_e idx, logic [BankW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_MODE:   fog_mode_r   = val[1:0];
      REG_SHIFT:  fog_shift_r  = val[ShiftW-1:0];
      REG_COLOR:  fog_color_r  = val[FogColW-1:0];
      REG_OFFSET: fog_offset_r = val[OffW-1:0];
      default:    dens_bank_r[int'(idx) - int'(REG_DENS_LO)] = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_pixel(logic [ColorW-1:0] color, logic [DepthW-1:0] depth, logic flag);
    pixel_in_t px;
    px.color = color;
    px.depth = depth;
    px.flag  = flag;
    pixels_to_send = {pixels_to_send, px};
  endtask

  // Sender empty and every predicted result retired. Checked on the falling edge so
  // the stream processes have settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixels_to_send.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
  endtask

  // Depth aimed at the table window: a little before the start, across all 32 entries
  // and a little past the end. Some depths are fully random.
  function automatic logic [DepthW-1:0] pick_depth();
    int step;
    int k;
    int base;
    step = 1024 >> fog_shift_r;
    if ($urandom_range(99) < 30) return DepthW'($urandom);
    if (step == 0) k = int'($urandom_range(4)) - 2;
    else k = int'($urandom_range(33 * step)) - step;
    base = int'(fog_offset_r) + k;
    if (base < 0) base = 0;
    if (base > 32767) base = 32767;
    return {base[14:0], 9'($urandom)};
  endfunction

  task automatic random_setup();
    int               pick;
    logic [1:0]       mode;
    logic [BankW-1:0] v;
    pick = int'($urandom_range(9));
    if (pick == 0) mode = FOG_OFF;
    else if (pick < 6) mode = FOG_FULL;
    else if (pick < 9) mode = FOG_ALPHA;
    else mode = ModeReserved;
    write_reg(REG_MODE, 56'(mode) | junk_above(2));

    pick = int'($urandom_range(7));
    case (pick)
      0:       v = 56'(0);
      1:       v = 56'(MaxShift);
      2:       v = 56'(15);
      default: v = 56'($urandom_range(15));
    endcase
    write_reg(REG_SHIFT, v | junk_above(ShiftW));

    pick = int'($urandom_range(7));
    if (pick == 0) v = '0;
    else if (pick == 1) v = 56'(21'h1F_FFFF);
    else v = 56'(21'($urandom));
    write_reg(REG_COLOR, v | junk_above(FogColW));

    pick = int'($urandom_range(7));
    if (pick == 0) v = '0;
    else if (pick == 1) v = 56'(15'h7FFF);
    else v = 56'(15'($urandom));
    write_reg(REG_OFFSET, v | junk_above(OffW));

    for (int i = 0; i < 4; i++) begin
      pick = int'($urandom_range(7));
      if (pick == 0) v = '0;
      else if (pick == 1) v = '1;
      else v = BankW'({$urandom, $urandom});
      write_reg(cfg_reg_e'(int'(REG_DENS_LO) + i), v);
    end
    @(negedge clk_i);
  endtask

  // Short directed part: reset state, every mode, every kind of density lookup.
  task automatic directed_part();
    logic [BankW-1:0] ramp [4];
    for (int i = 0; i < NumDens; i++) ramp[i / 8][(i % 8) * DensW +: DensW] = 7'(i * 4 + 3);

    // Fog is off after reset: even flagged pixels pass untouched, upper bits included.
    push_pixel('1, '1, 1'b1);
    push_pixel('0, '0, 1'b1);
    push_pixel(27'h5A5_A5A5, 24'hA5A5A5, 1'b0);
    wait_drained();

    // Full blend over a ramp table, widest step; fog color has the ignored bit set.
    write_reg(REG_MODE, 56'(FOG_FULL));
    write_reg(REG_SHIFT, 56'(0));
    write_reg(REG_COLOR, 56'(21'h1F_FFFF));
    write_reg(REG_OFFSET, 56'(0));
    for (int i = 0; i < 4; i++) write_reg(cfg_reg_e'(int'(REG_DENS_LO) + i), ramp[i]);
    @(negedge clk_i);
    push_pixel('1, '0, 1'b1);                            // first entry exactly
    push_pixel('0, '1, 1'b1);                            // beyond the last entry
    push_pixel(27'h3FF_FFFF, {15'(5 * 1024 + 300), 9'h1FF}, 1'b1);  // between entries
    push_pixel('1, '1, 1'b0);                            // flag clear in a fog mode
    push_pixel(27'h1000_000, {15'(31 * 1024 - 1), 9'h0}, 1'b1);     // just below the end
    wait_drained();

    // Alpha only with a zero step: only the sign of the offset matters.
    write_reg(REG_MODE, 56'(FOG_ALPHA));
    write_reg(REG_SHIFT, 56'(15));
    write_reg(REG_COLOR, 56'(21'h0A_5A5A));
    write_reg(REG_OFFSET, 56'(100));
    @(negedge clk_i);
    push_pixel('1, {15'(99), 9'h1FF}, 1'b1);
    push_pixel('1, {15'(100), 9'h0}, 1'b1);
    push_pixel('0, {15'(101), 9'h0}, 1'b1);
    wait_drained();

    // The reserved mode code with a one-unit step and the table starting at the top.
    write_reg(REG_MODE, 56'(ModeReserved));
    write_reg(REG_SHIFT, 56'(MaxShift));
    write_reg(REG_COLOR, 56'(0));
    write_reg(REG_OFFSET, 56'(15'h7FFF));
    @(negedge clk_i);
    push_pixel('1, '1, 1'b1);
    push_pixel('1, '0, 1'b1);
    wait_drained();

    // Full density, and a small negative offset whose quotient truncates to zero.
    write_reg(REG_MODE, 56'(FOG_FULL));
    write_reg(REG_SHIFT, 56'(4));
    write_reg(REG_OFFSET, 56'(20));
    write_reg(REG_COLOR, 56'(21'h15_2A55));
    for (int i = 0; i < 4; i++) write_reg(cfg_reg_e'(int'(REG_DENS_LO) + i), '1);
    @(negedge clk_i);
    push_pixel(27'h2AA_AAAA, {15'(15), 9'h0}, 1'b1);
    push_pixel(27'h155_5555, {15'(40), 9'h0}, 1'b1);
    push_pixel('0, '1, 1'b1);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Input side: the driver presents queued items with random gaps, and the
  // predictor records the expected result of each item as it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pixels_to_send.size() != 0) begin
        next_px = pixels_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, next_px.depth, next_px.color};
        s_axis_tuser  <= next_px.flag;
        send_gap = pick_gap(src_idle_pct);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      next_px.color = s_axis_tdata[ColorW-1:0];
      next_px.depth = s_axis_tdata[ColorW +: DepthW];
      next_px.flag  = s_axis_tuser;
      expected_pixels = {expected_pixels, fogged_pixel(next_px)};
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: the receiver stalls at random and, when asked, holds off for a
  // long stretch so the pipeline fills and the input stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap  = 0;
      hold_left = 0;
    end else begin
      if (sink_hold_req > 0) begin
        hold_left     = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_gap = pick_gap(sink_idle_pct);
      end
    end
  end

  // Each accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with no pixel outstanding", m_axis_tdata, '0);
      end else begin
        automatic pixel_out_t want = expected_pixels.pop_front();
        if (m_axis_tdata[ColorW-1:0] !== want.color)
          report_mismatch("result_color", 32'(m_axis_tdata[ColorW-1:0]), 32'(want.color));
        if (m_axis_tuser !== want.applied)
          report_mismatch("fog_applied", 32'(m_axis_tuser), 32'(want.applied));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed checks, then random phases, each under its own
  // configuration and idling pattern. Configuration changes only when drained.
  // ---------------------------------------------------------------------------
  initial begin
    fog_mode_r   = FOG_OFF;
    fog_shift_r  = '0;
    fog_color_r  = '0;
    fog_offset_r = '0;
    for (int i = 0; i < 4; i++) dens_bank_r[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct  = 20;
    sink_idle_pct = 20;
    directed_part();

    for (int phase = 0; phase < 12; phase++) begin
      random_setup();
      // Some phases run flat out on both sides; the others idle at random.
      case ($urandom_range(3))
        0:       begin src_idle_pct = 0;  sink_idle_pct = 0;  end
        1:       begin src_idle_pct = 50; sink_idle_pct = 10; end
        2:       begin src_idle_pct = 10; sink_idle_pct = 50; end
        default: begin src_idle_pct = 25; sink_idle_pct = 25; end
      endcase
      // In one phase the receiver holds off long while the sender keeps offering.
      if (phase == 3) begin
        src_idle_pct  = 0;
        sink_hold_req = 100;
      end
      for (int i = 0; i < 115; i++) begin
        push_pixel(ColorW'($urandom), pick_depth(), $urandom_range(99) < 85);
        // In another phase the sender pauses until every result is back.
        if (phase == 6 && i == 57) wait_drained();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("depth_fog_blend_top_tb: done, clean");
    end else begin
      $display("depth_fog_blend_top_tb: done, errors");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run of the stimulus above.
  initial begin
    #4ms;
    $display("depth_fog_blend_top_tb: done, errors");
    $finish;
  end

endmodule

// ----- depth_fog_blend_top.f -----
hw/rtl/dfb_pkg.sv
hw/rtl/dfb_density.sv
hw/rtl/dfb_blend.sv
hw/rtl/depth_fog_blend_top.sv
sim/depth_fog_blend_top_tb.sv
